// File: rtl/rv64_register_alu_with_muldiv_defines.svh
// Assertion macros for the RV64IM register ALU.
`ifndef RV64_REGISTER_ALU_WITH_MULDIV_DEFINES_SVH
`define RV64_REGISTER_ALU_WITH_MULDIV_DEFINES_SVH

// Always-true check: cond must hold at every clock edge out of reset.
`define RVALU_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rvalu invariant violated");

// Implication check: when ante holds, cons holds in the same cycle.
`define RVALU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rvalu implication violated");

// Delay check: ante is followed by cons after the delay given by dly.
`define RVALU_ASSERT_DELAY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("rvalu latency violated");

`endif

// File: rtl/rvalu_pkg.sv
// Types and constants shared by the RV64IM register ALU.
package rvalu_pkg;

    localparam int XLEN       = 64;
    localparam int MUL_STAGES = 4;
    localparam int DIV_STAGES = XLEN;
    // decode register + multiplier + divider + output register
    localparam int LATENCY    = 1 + MUL_STAGES + DIV_STAGES + 1;

    // funct7 encodings
    localparam logic [6:0] F7_BASE   = 7'd0;
    localparam logic [6:0] F7_MULDIV = 7'd1;
    localparam logic [6:0] F7_ALT    = 7'd32;

    // funct3 encodings (base / M-extension)
    localparam logic [2:0] F3_ADD_MUL     = 3'd0;
    localparam logic [2:0] F3_SLL_MULH    = 3'd1;
    localparam logic [2:0] F3_SLT_MULHSU  = 3'd2;
    localparam logic [2:0] F3_SLTU_MULHU  = 3'd3;
    localparam logic [2:0] F3_XOR_DIV     = 3'd4;
    localparam logic [2:0] F3_SR_DIVU     = 3'd5;
    localparam logic [2:0] F3_OR_REM      = 3'd6;
    localparam logic [2:0] F3_AND_REMU    = 3'd7;

    typedef struct packed {
        logic [2:0]      mode;
        logic [6:0]      variant;
        logic [XLEN-1:0] operand_a;
        logic [XLEN-1:0] operand_b;
    } req_t;

    typedef struct packed {
        logic [XLEN-1:0] result;
        logic            illegal;
    } rsp_t;

    // Where the final result comes from
    typedef enum logic [1:0] {
        SRC_ALU,
        SRC_MUL,
        SRC_QUO,
        SRC_REM
    } res_src_t;

    // Which half / signedness of the product
    typedef enum logic [1:0] {
        MK_LO,
        MK_HSS,
        MK_HSU,
        MK_HUU
    } mul_kind_t;

    // Side data carried through the multiplier
    typedef struct packed {
        res_src_t        src;
        logic            illegal;
        logic [XLEN-1:0] alu_res;
        logic [XLEN-1:0] dividend;
        logic [XLEN-1:0] divisor;
        logic            neg_q;
        logic            neg_r;
    } s1_t;

    // Side data carried through the divider
    typedef struct packed {
        res_src_t        src;
        logic            illegal;
        logic [XLEN-1:0] res;
        logic            neg_q;
        logic            neg_r;
    } s2_t;

endpackage

// File: rtl/rvalu_mul.sv
// Four-stage pipelined 64x64 multiplier with low/high half and signed correction.
module rvalu_mul
    import rvalu_pkg::*;
#(
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid_in,
    input  mul_kind_t        kind,
    input  logic [XLEN-1:0]  a,
    input  logic [XLEN-1:0]  b,
    input  logic [TAG_W-1:0] tag_in,
    output logic             valid_out,
    output logic [XLEN-1:0]  product,
    output logic [TAG_W-1:0] tag_out
);

    localparam int H = XLEN / 2;

    logic [3:0]           v_reg;
    mul_kind_t            k1_reg, k2_reg, k3_reg;
    logic [TAG_W-1:0]     t1_reg, t2_reg, t3_reg, t4_reg;
    logic [XLEN-1:0]      ll_reg, lh_reg, hl_reg, hh_reg;
    logic [XLEN-1:0]      ll2_reg, hh2_reg;
    logic [XLEN:0]        mid_reg;
    logic [XLEN-1:0]      c1_reg, c2_reg, c3_reg;
    logic [2*XLEN-1:0]    prod_reg;
    logic [XLEN-1:0]      res_reg;
    logic [XLEN-1:0]      corr_next;

    // correction for signed high products: subtract b if a<0, and a if b<0 (signed x signed only)
    always_comb
    begin
        corr_next = '0;
        if (a[XLEN-1] && (kind == MK_HSS || kind == MK_HSU))
        begin
            corr_next = b;
        end
        if (b[XLEN-1] && kind == MK_HSS)
        begin
            corr_next = corr_next + a;
        end
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[2:0], valid_in};
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        // stage 1: 32x32 partial products, zero-extended to the full width
        ll_reg <= XLEN'(a[H-1:0]) * XLEN'(b[H-1:0]);
        lh_reg <= XLEN'(a[H-1:0]) * XLEN'(b[XLEN-1:H]);
        hl_reg <= XLEN'(a[XLEN-1:H]) * XLEN'(b[H-1:0]);
        hh_reg <= XLEN'(a[XLEN-1:H]) * XLEN'(b[XLEN-1:H]);
        c1_reg <= corr_next;
        k1_reg <= kind;
        t1_reg <= tag_in;
        // stage 2: middle terms
        mid_reg <= {1'b0, lh_reg} + {1'b0, hl_reg};
        ll2_reg <= ll_reg;
        hh2_reg <= hh_reg;
        c2_reg  <= c1_reg;
        k2_reg  <= k1_reg;
        t2_reg  <= t1_reg;
        // stage 3: full product
        prod_reg <= {hh2_reg, ll2_reg} + {{(H-1){1'b0}}, mid_reg, {H{1'b0}}};
        c3_reg   <= c2_reg;
        k3_reg   <= k2_reg;
        t3_reg   <= t2_reg;
        // stage 4: half select and correction
        res_reg <= (k3_reg == MK_LO) ? prod_reg[XLEN-1:0]
                                     : prod_reg[2*XLEN-1:XLEN] - c3_reg;
        t4_reg  <= t3_reg;
    end

    assign valid_out = v_reg[3];
    assign product   = res_reg;
    assign tag_out   = t4_reg;

endmodule

// File: rtl/rvalu_div.sv
// Fully pipelined unsigned restoring divider, one quotient bit per stage.
module rvalu_div
    import rvalu_pkg::*;
#(
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid_in,
    input  logic [XLEN-1:0]  dividend,
    input  logic [XLEN-1:0]  divisor,
    input  logic [TAG_W-1:0] tag_in,
    output logic             valid_out,
    output logic [XLEN-1:0]  quotient,
    output logic [XLEN-1:0]  remainder,
    output logic [TAG_W-1:0] tag_out
);

    // index 0 is the input, index k the register of stage k
    logic                v_s   [0:DIV_STAGES];
    logic [XLEN-1:0]     rem_s [0:DIV_STAGES];
    logic [XLEN-1:0]     qd_s  [0:DIV_STAGES];
    logic [XLEN-1:0]     dvs_s [0:DIV_STAGES];
    logic [TAG_W-1:0]    tag_s [0:DIV_STAGES];

    assign v_s[0]   = valid_in;
    assign rem_s[0] = '0;
    assign qd_s[0]  = dividend;
    assign dvs_s[0] = divisor;
    assign tag_s[0] = tag_in;

    for (genvar k = 1; k <= DIV_STAGES; k++)
    begin : g_stage
        logic [XLEN+1:0] diff;
        logic            ge;

        // trial subtract of the shifted partial remainder
        assign diff = {1'b0, rem_s[k-1], qd_s[k-1][XLEN-1]} - {2'b00, dvs_s[k-1]};
        assign ge   = !diff[XLEN+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_s[k] <= 1'b0;
            end
            else
            begin
                v_s[k] <= v_s[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_s[k] <= ge ? diff[XLEN-1:0]
                           : {rem_s[k-1][XLEN-2:0], qd_s[k-1][XLEN-1]};
            qd_s[k]  <= {qd_s[k-1][XLEN-2:0], ge};
            dvs_s[k] <= dvs_s[k-1];
            tag_s[k] <= tag_s[k-1];
        end
    end

    assign valid_out = v_s[DIV_STAGES];
    assign quotient  = qd_s[DIV_STAGES];
    assign remainder = rem_s[DIV_STAGES];
    assign tag_out   = tag_s[DIV_STAGES];

endmodule

// File: rtl/rv64_register_alu_with_muldiv.sv
// Top level of the pipelined RV64IM register-register ALU.
//
// Usage:
//   Present an item on req (funct3 as mode, funct7 as variant, rs1/rs2 values)
//   and raise start for one cycle. busy is always low: the pipeline takes a
//   new item in every cycle, so one item per cycle is sustained.
//   Every item takes the same path, whatever its operation: done
//   is high for one cycle with rsp holding result and illegal. Items leave
//   in the order they entered.
//   The path is one decode/ALU register, four multiplier stages, 64
//   divider stages (one quotient bit each) and one output register; every
//   item walks the full chain so ordering stays fixed.
//   Invalid encodings give illegal = 1 and result = 0.
//   Reset clears all valid bits; items in flight are dropped and done stays
//   low until new items come out. The receiver cannot stall: each result is
//   shown for one cycle only.
`include "rv64_register_alu_with_muldiv_defines.svh"

module rv64_register_alu_with_muldiv
    import rvalu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    localparam int S1_W = $bits(s1_t);
    localparam int S2_W = $bits(s2_t);

    logic             accept;
    logic             v1_reg;
    s1_t              s1_reg, s1_next;
    mul_kind_t        mk_reg, mk_next;
    logic [XLEN-1:0]  a_reg, b_reg;

    logic             mul_valid;
    logic [XLEN-1:0]  mul_prod;
    logic [S1_W-1:0]  mul_tag;
    s1_t              m_s1;
    s2_t              d_in;

    logic             div_valid;
    logic [XLEN-1:0]  div_q, div_r;
    logic [S2_W-1:0]  div_tag;
    s2_t              d_out;

    logic             done_reg;
    rsp_t             rsp_reg, rsp_next;

    logic [2:0]       f3;
    logic [6:0]       f7;
    logic [XLEN-1:0]  opa, opb;
    logic [5:0]       shamt;
    logic             sa, sb;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign f3    = req.mode;
    assign f7    = req.variant;
    assign opa   = req.operand_a;
    assign opb   = req.operand_b;
    assign shamt = opb[5:0];
    assign sa    = opa[XLEN-1];
    assign sb    = opb[XLEN-1];

    // decode and base ALU
    always_comb
    begin
        s1_next          = '0;
        s1_next.src      = SRC_ALU;
        s1_next.dividend = opa;
        s1_next.divisor  = opb;
        mk_next          = MK_LO;
        if (f7 == F7_BASE)
        begin
            case (f3)
                F3_ADD_MUL:    s1_next.alu_res = opa + opb;
                F3_SLL_MULH:   s1_next.alu_res = opa << shamt;
                F3_SLT_MULHSU: s1_next.alu_res = {63'd0, $signed(opa) < $signed(opb)};
                F3_SLTU_MULHU: s1_next.alu_res = {63'd0, opa < opb};
                F3_XOR_DIV:    s1_next.alu_res = opa ^ opb;
                F3_SR_DIVU:    s1_next.alu_res = opa >> shamt;
                F3_OR_REM:     s1_next.alu_res = opa | opb;
                F3_AND_REMU:   s1_next.alu_res = opa & opb;
                default:       s1_next.alu_res = '0;
            endcase
        end
        else if (f7 == F7_MULDIV)
        begin
            case (f3)
                F3_ADD_MUL:
                begin
                    s1_next.src = SRC_MUL;
                    mk_next     = MK_LO;
                end
                F3_SLL_MULH:
                begin
                    s1_next.src = SRC_MUL;
                    mk_next     = MK_HSS;
                end
                F3_SLT_MULHSU:
                begin
                    s1_next.src = SRC_MUL;
                    mk_next     = MK_HSU;
                end
                F3_SLTU_MULHU:
                begin
                    s1_next.src = SRC_MUL;
                    mk_next     = MK_HUU;
                end
                F3_XOR_DIV, F3_OR_REM:
                begin
                    s1_next.src      = (f3 == F3_XOR_DIV) ? SRC_QUO : SRC_REM;
                    s1_next.dividend = sa ? -opa : opa;
                    s1_next.divisor  = sb ? -opb : opb;
                    // divide by zero keeps the all-ones quotient unsigned
                    s1_next.neg_q    = (sa ^ sb) && (opb != '0);
                    s1_next.neg_r    = sa;
                end
                F3_SR_DIVU:    s1_next.src = SRC_QUO;
                F3_AND_REMU:   s1_next.src = SRC_REM;
                default:       s1_next.src = SRC_ALU;
            endcase
        end
        else if (f7 == F7_ALT && f3 == F3_ADD_MUL)
        begin
            s1_next.alu_res = opa - opb;
        end
        else if (f7 == F7_ALT && f3 == F3_SR_DIVU)
        begin
            s1_next.alu_res = $unsigned($signed(opa) >>> shamt);
        end
        else
        begin
            s1_next.illegal = 1'b1;
        end
    end

    // decode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        mk_reg <= mk_next;
        a_reg  <= opa;
        b_reg  <= opb;
    end

    rvalu_mul #(
        .TAG_W (S1_W)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v1_reg),
        .kind      (mk_reg),
        .a         (a_reg),
        .b         (b_reg),
        .tag_in    (s1_reg),
        .valid_out (mul_valid),
        .product   (mul_prod),
        .tag_out   (mul_tag)
    );

    // merge multiplier output into the side data
    always_comb
    begin
        m_s1          = s1_t'(mul_tag);
        d_in.src      = m_s1.src;
        d_in.illegal  = m_s1.illegal;
        d_in.res      = (m_s1.src == SRC_MUL) ? mul_prod : m_s1.alu_res;
        d_in.neg_q    = m_s1.neg_q;
        d_in.neg_r    = m_s1.neg_r;
    end

    rvalu_div #(
        .TAG_W (S2_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (mul_valid),
        .dividend  (m_s1.dividend),
        .divisor   (m_s1.divisor),
        .tag_in    (d_in),
        .valid_out (div_valid),
        .quotient  (div_q),
        .remainder (div_r),
        .tag_out   (div_tag)
    );

    // sign fix and final select
    always_comb
    begin
        d_out            = s2_t'(div_tag);
        rsp_next.illegal = d_out.illegal;
        case (d_out.src)
            SRC_QUO: rsp_next.result = d_out.neg_q ? -div_q : div_q;
            SRC_REM: rsp_next.result = d_out.neg_r ? -div_r : div_r;
            default: rsp_next.result = d_out.res;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // checks
    `RVALU_ASSERT_DELAY(a_latency, start && !busy, 70, done)
    `RVALU_ASSERT_IMPL(a_illegal_zero, done && rsp.illegal, rsp.result == '0)
    `RVALU_ASSERT_IMPL(a_mul_path, v1_reg && s1_reg.src == SRC_ALU, mk_reg == MK_LO)

endmodule
